@@ hw/rtl/mbe_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the escape-time pixel engine.
// No dependencies; used by every module of the block.
package mbe_pkg;

  // field and register widths
  localparam int PIX_W   = 12;
  localparam int DIM_W   = 13;
  localparam int CNT_W   = 16;
  localparam int PAL_W   = 8;
  localparam int COORD_W = 32;
  localparam int ZOOM_W  = 32;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 5;
  localparam int REG_IDX_W = 3;

  // fixed-point formats
  localparam int COORD_FRAC_BITS = 26;
  localparam int ZOOM_FRAC_BITS  = 24;
  localparam int ZOOM_SHIFT      = COORD_FRAC_BITS - ZOOM_FRAC_BITS;
  localparam int ZC_W            = ZOOM_W + ZOOM_SHIFT;
  localparam int SQ_W            = 2 * COORD_W;
  localparam int BOUND_BIT       = 4 + 2 * COORD_FRAC_BITS;

  // palette scaling
  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_MAX         = PALETTE_ENTRIES - 1;
  localparam int PAL_SCALE       = 2 * PAL_MAX;
  localparam int PAL_NUM_W       = 25;

  // pixel mapping products and divider
  localparam int MULT3_W      = PIX_W + 2;
  localparam int PROD_W       = ZC_W + MULT3_W;
  localparam int DIVIDEND_W   = PROD_W;
  localparam int DIVISOR_W    = CNT_W + 1;
  localparam int REM_W        = DIVISOR_W + 1;
  localparam int DIV_RADIX_BITS = 2;
  localparam int DIV_CYCLES   = DIVIDEND_W / DIV_RADIX_BITS;
  localparam int DIV_CNT_W    = $clog2(DIV_CYCLES);

  // register map
  typedef logic [REG_IDX_W-1:0] reg_idx_t;
  localparam reg_idx_t REG_LIMIT  = 3'd0;
  localparam reg_idx_t REG_ZOOM   = 3'd1;
  localparam reg_idx_t REG_OFF_RE = 3'd2;
  localparam reg_idx_t REG_OFF_IM = 3'd3;
  localparam reg_idx_t REG_WIDTH  = 3'd4;
  localparam reg_idx_t REG_HEIGHT = 3'd5;

  // reset values
  localparam logic [CNT_W-1:0]  LIMIT_RST = 16'd100;
  localparam logic [ZOOM_W-1:0] ZOOM_RST  = 32'h0100_0000;
  localparam logic [DIM_W-1:0]  DIM_RST   = 13'd1;

  // divider operand select
  typedef logic [1:0] div_sel_t;
  localparam div_sel_t DIV_SEL_RE  = 2'd0;
  localparam div_sel_t DIV_SEL_IM  = 2'd1;
  localparam div_sel_t DIV_SEL_PAL = 2'd2;

  typedef struct packed {
    logic     load_pix;
    logic     load_prod;
    logic     div_start;
    div_sel_t div_sel;
    logic     cap_re;
    logic     cap_im;
    logic     iter_init;
    logic     iter_mul;
    logic     iter_step;
    logic     set_esc;
    logic     cap_pal;
    logic     load_out;
  } mbe_cmd_t;

  typedef struct packed {
    logic div_done;
    logic limit_hit;
    logic limit_zero;
    logic mag_over;
  } mbe_stat_t;

endpackage

@@ hw/rtl/mbe_div.sv @@
`timescale 1ns / 1ps
// Restoring unsigned divider, two quotient bits per cycle.
// Depends on mbe_pkg.
module mbe_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [mbe_pkg::DIVIDEND_W-1:0]    dividend,
  input  logic [mbe_pkg::DIVISOR_W-1:0]     divisor,
  output logic                              done,
  output logic [mbe_pkg::DIVIDEND_W-1:0]    quotient
);

  logic [mbe_pkg::DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [mbe_pkg::REM_W-1:0]      rem_r, rem_nxt;
  logic [mbe_pkg::DIVISOR_W-1:0]  dvs_r;
  logic [mbe_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic                           busy_r;
  logic                           done_r;
  logic                           last;

  always_comb begin
    logic [mbe_pkg::REM_W-1:0]      rem_v;
    logic [mbe_pkg::DIVIDEND_W-1:0] quo_v;
    rem_v = rem_r;
    quo_v = quo_r;
    for (int k = 0; k < mbe_pkg::DIV_RADIX_BITS; k++) begin
      rem_v = {rem_v[mbe_pkg::REM_W-2:0], quo_v[mbe_pkg::DIVIDEND_W-1]};
      quo_v = {quo_v[mbe_pkg::DIVIDEND_W-2:0], 1'b0};
      if (rem_v >= mbe_pkg::REM_W'(dvs_r)) begin
        rem_v    = rem_v - mbe_pkg::REM_W'(dvs_r);
        quo_v[0] = 1'b1;
      end
    end
    rem_nxt = rem_v;
    quo_nxt = quo_v;
  end

  assign last = (cnt_r == mbe_pkg::DIV_CNT_W'(mbe_pkg::DIV_CYCLES - 1));

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (last) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ hw/rtl/mbe_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer of the pixel engine: mapping, iteration loop, palette, result transfer.
// Depends on mbe_pkg.
module mbe_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  mbe_pkg::mbe_stat_t stat,
  output mbe_pkg::mbe_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_MAP      = 4'd1;
  localparam logic [3:0] S_DRE_GO   = 4'd2;
  localparam logic [3:0] S_DRE_WAIT = 4'd3;
  localparam logic [3:0] S_DIM_GO   = 4'd4;
  localparam logic [3:0] S_DIM_WAIT = 4'd5;
  localparam logic [3:0] S_MUL      = 4'd6;
  localparam logic [3:0] S_UPD      = 4'd7;
  localparam logic [3:0] S_PAL_GO   = 4'd8;
  localparam logic [3:0] S_PAL_WAIT = 4'd9;
  localparam logic [3:0] S_OUT      = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_pix = 1'b1;
          state_nxt    = S_MAP;
        end
      end
      S_MAP: begin
        cmd.load_prod = 1'b1;
        state_nxt     = S_DRE_GO;
      end
      S_DRE_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = mbe_pkg::DIV_SEL_RE;
        state_nxt     = S_DRE_WAIT;
      end
      S_DRE_WAIT: begin
        if (stat.div_done) begin
          cmd.cap_re = 1'b1;
          state_nxt  = S_DIM_GO;
        end
      end
      S_DIM_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = mbe_pkg::DIV_SEL_IM;
        state_nxt     = S_DIM_WAIT;
      end
      S_DIM_WAIT: begin
        if (stat.div_done) begin
          cmd.cap_im    = 1'b1;
          cmd.iter_init = 1'b1;
          state_nxt     = S_MUL;
        end
      end
      S_MUL: begin
        cmd.iter_mul = 1'b1;
        state_nxt    = S_UPD;
      end
      S_UPD: begin
        if (stat.limit_hit) begin
          state_nxt = S_PAL_GO;
        end else if (stat.mag_over) begin
          cmd.set_esc = 1'b1;
          state_nxt   = S_PAL_GO;
        end else begin
          cmd.iter_step = 1'b1;
          state_nxt     = S_MUL;
        end
      end
      S_PAL_GO: begin
        if (stat.limit_zero) begin
          cmd.cap_pal = 1'b1;
          state_nxt   = S_OUT;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = mbe_pkg::DIV_SEL_PAL;
          state_nxt     = S_PAL_WAIT;
        end
      end
      S_PAL_WAIT: begin
        if (stat.div_done) begin
          cmd.cap_pal = 1'b1;
          state_nxt   = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ hw/rtl/mbe_dp.sv @@
`timescale 1ns / 1ps
// Datapath: point mapping, Z = Z^2 + c iteration, palette scaling, result register.
// Depends on mbe_pkg and mbe_div.
module mbe_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mbe_pkg::mbe_cmd_t                 cmd,
  output mbe_pkg::mbe_stat_t                stat,
  input  logic [mbe_pkg::PIX_W-1:0]         in_pixel_x,
  input  logic [mbe_pkg::PIX_W-1:0]         in_pixel_y,
  input  logic [mbe_pkg::CNT_W-1:0]         iteration_limit,
  input  logic [mbe_pkg::ZOOM_W-1:0]        zoom_scale,
  input  logic signed [mbe_pkg::COORD_W-1:0] center_offset_re,
  input  logic signed [mbe_pkg::COORD_W-1:0] center_offset_im,
  input  logic [mbe_pkg::DIM_W-1:0]         image_width,
  input  logic [mbe_pkg::DIM_W-1:0]         image_height,
  output logic [mbe_pkg::PIX_W-1:0]         out_x,
  output logic [mbe_pkg::PIX_W-1:0]         out_y,
  output logic [mbe_pkg::CNT_W-1:0]         out_iteration_count,
  output logic                              out_escaped,
  output logic [mbe_pkg::PAL_W-1:0]         out_palette_index
);

  function automatic logic signed [mbe_pkg::COORD_W-1:0] sat_coord(
    input logic signed [mbe_pkg::SQ_W-1:0] v
  );
    logic signed [mbe_pkg::COORD_W-1:0] r;
    if (v[mbe_pkg::SQ_W-1:mbe_pkg::COORD_W-1] == {(mbe_pkg::COORD_W+1){v[mbe_pkg::SQ_W-1]}}) begin
      r = v[mbe_pkg::COORD_W-1:0];
    end else if (v[mbe_pkg::SQ_W-1]) begin
      r = {1'b1, {(mbe_pkg::COORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(mbe_pkg::COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

  logic [mbe_pkg::PIX_W-1:0]  px_r, py_r;
  logic [mbe_pkg::PROD_W-1:0] prod_re_r, prod_im_r;
  logic [mbe_pkg::PROD_W-1:0] prod_re_nxt, prod_im_nxt;
  logic [mbe_pkg::ZC_W-1:0]   zc;
  logic [mbe_pkg::MULT3_W-1:0] px3, py2;

  logic signed [mbe_pkg::COORD_W-1:0] cre_r, cim_r, zr_r, zi_r;
  logic signed [mbe_pkg::COORD_W-1:0] cre_nxt, cim_nxt, zr_nxt, zi_nxt;
  logic signed [mbe_pkg::SQ_W-1:0]    sq_re_r, sq_im_r, cross_r;
  logic signed [mbe_pkg::SQ_W-1:0]    q_s, zc_s, diff, nr_full, ni_full;
  logic [mbe_pkg::SQ_W:0]             mag;
  logic [mbe_pkg::CNT_W-1:0]          count_r;
  logic                               esc_r;
  logic [mbe_pkg::PAL_W-1:0]          pal_r;

  logic [mbe_pkg::PAL_NUM_W-1:0]      pal_num;
  logic [mbe_pkg::DIVIDEND_W-1:0]     div_a;
  logic [mbe_pkg::DIVISOR_W-1:0]      div_b;
  logic [mbe_pkg::DIVIDEND_W-1:0]     div_q;
  logic                               div_done;
  logic [mbe_pkg::DIM_W-1:0]          w_eff, h_eff;

  logic [mbe_pkg::PIX_W-1:0]          out_x_r, out_y_r;
  logic [mbe_pkg::CNT_W-1:0]          out_cnt_r;
  logic                               out_esc_r;
  logic [mbe_pkg::PAL_W-1:0]          out_pal_r;

  // pixel mapping products
  assign zc  = mbe_pkg::ZC_W'(zoom_scale) << mbe_pkg::ZOOM_SHIFT;
  assign px3 = mbe_pkg::MULT3_W'(px_r) + {1'b0, px_r, 1'b0};
  assign py2 = {1'b0, py_r, 1'b0};
  assign prod_re_nxt = mbe_pkg::PROD_W'(zc) * mbe_pkg::PROD_W'(px3);
  assign prod_im_nxt = mbe_pkg::PROD_W'(zc) * mbe_pkg::PROD_W'(py2);

  assign w_eff = (image_width == '0) ? mbe_pkg::DIM_W'(1) : image_width;
  assign h_eff = (image_height == '0) ? mbe_pkg::DIM_W'(1) : image_height;

  assign pal_num = mbe_pkg::PAL_NUM_W'(count_r) * mbe_pkg::PAL_NUM_W'(mbe_pkg::PAL_SCALE)
                 + mbe_pkg::PAL_NUM_W'(iteration_limit);

  always_comb begin
    case (cmd.div_sel)
      mbe_pkg::DIV_SEL_RE: begin
        div_a = prod_re_r;
        div_b = mbe_pkg::DIVISOR_W'(w_eff);
      end
      mbe_pkg::DIV_SEL_IM: begin
        div_a = prod_im_r;
        div_b = mbe_pkg::DIVISOR_W'(h_eff);
      end
      mbe_pkg::DIV_SEL_PAL: begin
        div_a = mbe_pkg::DIVIDEND_W'(pal_num);
        div_b = {iteration_limit, 1'b0};
      end
      default: begin
        div_a = prod_re_r;
        div_b = mbe_pkg::DIVISOR_W'(w_eff);
      end
    endcase
  end

  mbe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  // c = -k*z + offset + quotient, saturated
  assign q_s  = $signed(mbe_pkg::SQ_W'(div_q));
  assign zc_s = $signed(mbe_pkg::SQ_W'(zc));
  assign cre_nxt = sat_coord(q_s - (zc_s <<< 1) + mbe_pkg::SQ_W'(center_offset_re));
  assign cim_nxt = sat_coord(q_s - zc_s + mbe_pkg::SQ_W'(center_offset_im));

  // iteration step from registered products
  assign diff    = sq_re_r - sq_im_r;
  assign nr_full = (diff >>> mbe_pkg::COORD_FRAC_BITS) + mbe_pkg::SQ_W'(cre_r);
  assign ni_full = (cross_r >>> (mbe_pkg::COORD_FRAC_BITS - 1)) + mbe_pkg::SQ_W'(cim_r);
  assign zr_nxt  = sat_coord(nr_full);
  assign zi_nxt  = sat_coord(ni_full);
  assign mag     = {1'b0, sq_re_r} + {1'b0, sq_im_r};

  always_ff @(posedge clk) begin
    if (cmd.load_pix) begin
      px_r <= in_pixel_x;
      py_r <= in_pixel_y;
    end
    if (cmd.load_prod) begin
      prod_re_r <= prod_re_nxt;
      prod_im_r <= prod_im_nxt;
    end
    if (cmd.cap_re) begin
      cre_r <= cre_nxt;
    end
    if (cmd.cap_im) begin
      cim_r <= cim_nxt;
    end
    if (cmd.iter_init) begin
      zr_r    <= '0;
      zi_r    <= '0;
      count_r <= '0;
      esc_r   <= 1'b0;
    end else if (cmd.iter_step) begin
      zr_r    <= zr_nxt;
      zi_r    <= zi_nxt;
      count_r <= count_r + 1'b1;
    end else if (cmd.set_esc) begin
      esc_r <= 1'b1;
    end
    if (cmd.iter_mul) begin
      sq_re_r <= mbe_pkg::SQ_W'(zr_r) * mbe_pkg::SQ_W'(zr_r);
      sq_im_r <= mbe_pkg::SQ_W'(zi_r) * mbe_pkg::SQ_W'(zi_r);
      cross_r <= mbe_pkg::SQ_W'(zr_r) * mbe_pkg::SQ_W'(zi_r);
    end
    if (cmd.cap_pal) begin
      pal_r <= (iteration_limit == '0) ? '0 : div_q[mbe_pkg::PAL_W-1:0];
    end
    if (cmd.load_out) begin
      out_x_r   <= px_r;
      out_y_r   <= py_r;
      out_cnt_r <= count_r;
      out_esc_r <= esc_r;
      out_pal_r <= pal_r;
    end
  end

  assign stat.div_done   = div_done;
  assign stat.limit_hit  = (count_r >= iteration_limit);
  assign stat.limit_zero = (iteration_limit == '0);
  assign stat.mag_over   = |mag[mbe_pkg::SQ_W:mbe_pkg::BOUND_BIT];

  assign out_x               = out_x_r;
  assign out_y               = out_y_r;
  assign out_iteration_count = out_cnt_r;
  assign out_escaped         = out_esc_r;
  assign out_palette_index   = out_pal_r;

endmodule

@@ hw/rtl/mandelbrot_escape_time_pixel.sv @@
`timescale 1ns / 1ps
// Top level of the escape-time pixel engine: register file, sequencer, datapath.
// Depends on mbe_pkg, mbe_ctrl, mbe_dp.
//
//   channel   direction  handshake              payload
//   in_       input      in_valid / in_ready    in_pixel_x, in_pixel_y
//   out_      output     out_valid / out_ready  out_x, out_y, out_iteration_count,
//                                               out_escaped, out_palette_index
//   cfg       input      psel / penable / pready  paddr, pwrite, pwdata, prdata
//
// One pixel at a time; a zero limit skips the palette division. The next input can
// be taken in the cycle after the result is loaded. Each iteration runs a product
// stage, then an update stage; the shared divider runs for the real mapping, the
// imaginary mapping and the palette scale, each run followed by a capture. A waiting
// result stalls the engine only at the next result load.
// Reset is synchronous; registers return to defaults.
module mandelbrot_escape_time_pixel (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mbe_pkg::PIX_W-1:0]         in_pixel_x,
  input  logic [mbe_pkg::PIX_W-1:0]         in_pixel_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mbe_pkg::PIX_W-1:0]         out_x,
  output logic [mbe_pkg::PIX_W-1:0]         out_y,
  output logic [mbe_pkg::CNT_W-1:0]         out_iteration_count,
  output logic                              out_escaped,
  output logic [mbe_pkg::PAL_W-1:0]         out_palette_index,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mbe_pkg::ADDR_W-1:0]        paddr,
  input  logic [mbe_pkg::DATA_W-1:0]        pwdata,
  output logic [mbe_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  logic [mbe_pkg::CNT_W-1:0]   limit_r;
  logic [mbe_pkg::ZOOM_W-1:0]  zoom_r;
  logic [mbe_pkg::COORD_W-1:0] off_re_r, off_im_r;
  logic [mbe_pkg::DIM_W-1:0]   width_r, height_r;
  logic                        wr_en;
  mbe_pkg::reg_idx_t           reg_idx;

  mbe_pkg::mbe_cmd_t  cmd;
  mbe_pkg::mbe_stat_t stat;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[mbe_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= mbe_pkg::LIMIT_RST;
      zoom_r   <= mbe_pkg::ZOOM_RST;
      off_re_r <= '0;
      off_im_r <= '0;
      width_r  <= mbe_pkg::DIM_RST;
      height_r <= mbe_pkg::DIM_RST;
    end else if (wr_en) begin
      case (reg_idx)
        mbe_pkg::REG_LIMIT:  limit_r  <= pwdata[mbe_pkg::CNT_W-1:0];
        mbe_pkg::REG_ZOOM:   zoom_r   <= pwdata[mbe_pkg::ZOOM_W-1:0];
        mbe_pkg::REG_OFF_RE: off_re_r <= pwdata[mbe_pkg::COORD_W-1:0];
        mbe_pkg::REG_OFF_IM: off_im_r <= pwdata[mbe_pkg::COORD_W-1:0];
        mbe_pkg::REG_WIDTH:  width_r  <= pwdata[mbe_pkg::DIM_W-1:0];
        mbe_pkg::REG_HEIGHT: height_r <= pwdata[mbe_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mbe_pkg::REG_LIMIT:  prdata = mbe_pkg::DATA_W'(limit_r);
      mbe_pkg::REG_ZOOM:   prdata = zoom_r;
      mbe_pkg::REG_OFF_RE: prdata = off_re_r;
      mbe_pkg::REG_OFF_IM: prdata = off_im_r;
      mbe_pkg::REG_WIDTH:  prdata = mbe_pkg::DATA_W'(width_r);
      mbe_pkg::REG_HEIGHT: prdata = mbe_pkg::DATA_W'(height_r);
      default:             prdata = '0;
    endcase
  end

  mbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mbe_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_pixel_x          (in_pixel_x),
    .in_pixel_y          (in_pixel_y),
    .iteration_limit     (limit_r),
    .zoom_scale          (zoom_r),
    .center_offset_re    ($signed(off_re_r)),
    .center_offset_im    ($signed(off_im_r)),
    .image_width         (width_r),
    .image_height        (height_r),
    .out_x               (out_x),
    .out_y               (out_y),
    .out_iteration_count (out_iteration_count),
    .out_escaped         (out_escaped),
    .out_palette_index   (out_palette_index)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a pixel is in flight");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_iteration_count <= limit_r))
    else $error("iteration count above limit");

  a_escape_before_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_escaped) |-> (out_iteration_count < limit_r))
    else $error("escape flagged at the limit");

  a_palette_top: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (limit_r != '0) && (out_iteration_count == limit_r))
      |-> (out_palette_index == mbe_pkg::PAL_W'(mbe_pkg::PAL_MAX)))
    else $error("palette index not at top for a pixel that hit the limit");
`endif

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the escape-time pixel engine: directed views, then random views.
// Depends on mbe_pkg and mandelbrot_escape_time_pixel; predicts each pixel result itself.
module tb;

  localparam longint unsigned ESC_BOUND = 64'd16 << (2 * mbe_pkg::COORD_FRAC_BITS);
  localparam longint unsigned ZOOM_CAP  = 64'd1 << 40;

  typedef struct packed {
    logic [mbe_pkg::CNT_W-1:0]          limit;
    logic [mbe_pkg::ZOOM_W-1:0]         zoom;
    logic signed [mbe_pkg::COORD_W-1:0] off_re;
    logic signed [mbe_pkg::COORD_W-1:0] off_im;
    logic [mbe_pkg::DIM_W-1:0]          width;
    logic [mbe_pkg::DIM_W-1:0]          height;
  } view_t;

  typedef struct packed {
    logic [mbe_pkg::PIX_W-1:0] x;
    logic [mbe_pkg::PIX_W-1:0] y;
  } pixel_t;

  typedef struct packed {
    logic [mbe_pkg::PIX_W-1:0] x;
    logic [mbe_pkg::PIX_W-1:0] y;
    logic [mbe_pkg::CNT_W-1:0] count;
    logic                      escaped;
    logic [mbe_pkg::PAL_W-1:0] pal;
  } pixel_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [mbe_pkg::PIX_W-1:0]  in_pixel_x = '0;
  logic [mbe_pkg::PIX_W-1:0]  in_pixel_y = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [mbe_pkg::PIX_W-1:0]  out_x;
  logic [mbe_pkg::PIX_W-1:0]  out_y;
  logic [mbe_pkg::CNT_W-1:0]  out_iteration_count;
  logic                       out_escaped;
  logic [mbe_pkg::PAL_W-1:0]  out_palette_index;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [mbe_pkg::ADDR_W-1:0] paddr = '0;
  logic [mbe_pkg::DATA_W-1:0] pwdata = '0;
  logic [mbe_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  view_t         view;
  pixel_t        pixel_q[$];
  pixel_result_t escape_q[$];
  pixel_result_t front;
  logic          in_fire = 1'b0;
  logic          steady = 1'b0;
  int            pixels_sent = 0;
  int            pixels_taken = 0;
  int            mismatches = 0;

  mandelbrot_escape_time_pixel u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_pixel_x          (in_pixel_x),
    .in_pixel_y          (in_pixel_y),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_x               (out_x),
    .out_y               (out_y),
    .out_iteration_count (out_iteration_count),
    .out_escaped         (out_escaped),
    .out_palette_index   (out_palette_index),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic pixel_result_t escape_time(input logic [mbe_pkg::PIX_W-1:0] px,
                                                input logic [mbe_pkg::PIX_W-1:0] py);
    longint unsigned w, h, zc, lim, cnt, mag, pal;
    longint          cre, cim, zr, zi, nr, ni;
    logic            esc;
    pixel_result_t   r;
    w = (view.width == 0) ? 1 : view.width;
    h = (view.height == 0) ? 1 : view.height;
    zc = view.zoom;
    zc = zc << mbe_pkg::ZOOM_SHIFT;
    if (zc > ZOOM_CAP) begin
      zc = ZOOM_CAP;
    end
    cre = clamp32(-2 * longint'(zc) + longint'(view.off_re) + longint'((zc * 3 * px) / w));
    cim = clamp32(-1 * longint'(zc) + longint'(view.off_im) + longint'((zc * 2 * py) / h));
    zr = 0;
    zi = 0;
    cnt = 0;
    esc = 1'b0;
    lim = view.limit;
    while (cnt < lim && !esc) begin
      mag = zr * zr;
      mag = mag + zi * zi;
      if (mag >= ESC_BOUND) begin
        esc = 1'b1;
      end else begin
        nr = ((zr * zr - zi * zi) >>> mbe_pkg::COORD_FRAC_BITS) + cre;
        ni = ((2 * zr * zi) >>> mbe_pkg::COORD_FRAC_BITS) + cim;
        zr = clamp32(nr);
        zi = clamp32(ni);
        cnt++;
      end
    end
    pal = (lim == 0) ? 0 : (2 * cnt * mbe_pkg::PAL_MAX + lim) / (2 * lim);
    r.x = px;
    r.y = py;
    r.count = cnt[mbe_pkg::CNT_W-1:0];
    r.escaped = esc;
    r.pal = pal[mbe_pkg::PAL_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t ns: %s", $time, msg);
  endtask

  // input channel: hold until transfer, then advance or idle
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pixel_q.size() != 0 && (steady || $urandom_range(0, 99) >= 17)) begin
        in_valid   <= 1'b1;
        in_pixel_x <= pixel_q[0].x;
        in_pixel_y <= pixel_q[0].y;
        void'(pixel_q.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= steady || ($urandom_range(0, 99) >= 17);
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        escape_q.insert(escape_q.size(), escape_time(in_pixel_x, in_pixel_y));
        pixels_taken++;
      end
      if (out_valid && out_ready) begin
        if (escape_q.size() == 0) begin
          report_mismatch($sformatf("result (%0d,%0d) with nothing pending", out_x, out_y));
        end else begin
          front = escape_q.pop_front();
          if (out_x != front.x)
            report_mismatch($sformatf("out_x got %0d expected %0d", out_x, front.x));
          if (out_y != front.y)
            report_mismatch($sformatf("(%0d,%0d) out_y got %0d", front.x, front.y, out_y));
          if (out_iteration_count != front.count)
            report_mismatch($sformatf("(%0d,%0d) count got %0d expected %0d",
                                      front.x, front.y, out_iteration_count, front.count));
          if (out_escaped != front.escaped)
            report_mismatch($sformatf("(%0d,%0d) escaped got %0b expected %0b",
                                      front.x, front.y, out_escaped, front.escaped));
          if (out_palette_index != front.pal)
            report_mismatch($sformatf("(%0d,%0d) palette got %0d expected %0d",
                                      front.x, front.y, out_palette_index, front.pal));
        end
      end
    end
  end

  task automatic write_reg(input mbe_pkg::reg_idx_t idx,
                           input logic [mbe_pkg::DATA_W-1:0] value);
    case (idx)
      mbe_pkg::REG_LIMIT:  view.limit  = value[mbe_pkg::CNT_W-1:0];
      mbe_pkg::REG_ZOOM:   view.zoom   = value[mbe_pkg::ZOOM_W-1:0];
      mbe_pkg::REG_OFF_RE: view.off_re = value[mbe_pkg::COORD_W-1:0];
      mbe_pkg::REG_OFF_IM: view.off_im = value[mbe_pkg::COORD_W-1:0];
      mbe_pkg::REG_WIDTH:  view.width  = value[mbe_pkg::DIM_W-1:0];
      mbe_pkg::REG_HEIGHT: view.height = value[mbe_pkg::DIM_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_view(input logic [mbe_pkg::CNT_W-1:0] limit,
                              input logic [mbe_pkg::ZOOM_W-1:0] zoom,
                              input logic [mbe_pkg::COORD_W-1:0] re,
                              input logic [mbe_pkg::COORD_W-1:0] im,
                              input logic [mbe_pkg::DIM_W-1:0] w,
                              input logic [mbe_pkg::DIM_W-1:0] h);
    write_reg(mbe_pkg::REG_LIMIT, mbe_pkg::DATA_W'(limit));
    write_reg(mbe_pkg::REG_ZOOM, zoom);
    write_reg(mbe_pkg::REG_OFF_RE, re);
    write_reg(mbe_pkg::REG_OFF_IM, im);
    write_reg(mbe_pkg::REG_WIDTH, mbe_pkg::DATA_W'(w));
    write_reg(mbe_pkg::REG_HEIGHT, mbe_pkg::DATA_W'(h));
  endtask

  task automatic queue_pixel(input logic [mbe_pkg::PIX_W-1:0] x,
                             input logic [mbe_pkg::PIX_W-1:0] y);
    pixel_t pix;
    pix.x = x;
    pix.y = y;
    pixel_q.insert(pixel_q.size(), pix);
    pixels_sent++;
  endtask

  // wait until the engine is idle with nothing in flight
  task automatic drain();
    while (pixels_taken != pixels_sent || escape_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [mbe_pkg::COORD_W-1:0] random_offset();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
    end
    if (pick == 7) begin
      return 32'h8000_0000;
    end
    if (pick == 8) begin
      return 32'h7FFF_FFFF;
    end
    return $urandom;
  endfunction

  function automatic logic [mbe_pkg::DIM_W-1:0] random_dim();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      return '0;
    end
    if (pick == 1) begin
      return 13'd8191;
    end
    if (pick == 2) begin
      return mbe_pkg::DIM_W'($urandom);
    end
    return mbe_pkg::DIM_W'($urandom_range(1, 4096));
  endfunction

  initial begin
    #40_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int unsigned                pick, span_x, span_y;
    logic [mbe_pkg::CNT_W-1:0]  lim;
    logic [mbe_pkg::ZOOM_W-1:0] zm;
    logic [mbe_pkg::PIX_W-1:0]  x, y;
    view.limit  = mbe_pkg::LIMIT_RST;
    view.zoom   = mbe_pkg::ZOOM_RST;
    view.off_re = '0;
    view.off_im = '0;
    view.width  = mbe_pkg::DIM_RST;
    view.height = mbe_pkg::DIM_RST;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // reset view: corners, far ones saturate
    queue_pixel(12'd0, 12'd0);
    queue_pixel(12'd4095, 12'd4095);
    queue_pixel(12'd4095, 12'd0);
    queue_pixel(12'd0, 12'd4095);

    // 3x2 grid on whole numbers: inside points run to the limit
    drain();
    program_view(16'd100, mbe_pkg::ZOOM_RST, '0, '0, 13'd3, 13'd2);
    queue_pixel(12'd2, 12'd1);
    queue_pixel(12'd1, 12'd1);
    queue_pixel(12'd0, 12'd1);
    queue_pixel(12'd0, 12'd0);
    queue_pixel(12'd1, 12'd0);

    // zero limit
    drain();
    write_reg(mbe_pkg::REG_LIMIT, 32'd0);
    queue_pixel(12'd2, 12'd1);
    queue_pixel(12'd0, 12'd0);

    // limit of one: large Z on the last step is not an escape
    drain();
    program_view(16'd1, mbe_pkg::ZOOM_RST, '0, '0, 13'd1, 13'd1);
    queue_pixel(12'd4095, 12'd4095);
    queue_pixel(12'd0, 12'd0);

    // limit of two, escape at one: palette half rounds up
    drain();
    write_reg(mbe_pkg::REG_LIMIT, 32'd2);
    queue_pixel(12'd4095, 12'd4095);

    // zero zoom, extreme offsets, zero width
    drain();
    program_view(16'd100, '0, 32'h8000_0000, 32'h7FFF_FFFF, 13'd0, 13'd8191);
    queue_pixel(12'd0, 12'd0);
    queue_pixel(12'd4095, 12'd4095);

    // largest zoom, zero height
    drain();
    program_view(16'd100, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 13'd8191, 13'd0);
    queue_pixel(12'd4095, 12'd4095);
    queue_pixel(12'd0, 12'd0);

    // largest limit at the origin
    drain();
    program_view(16'hFFFF, mbe_pkg::ZOOM_RST, '0, '0, 13'd3, 13'd2);
    queue_pixel(12'd2, 12'd1);

    for (int chunk = 0; chunk < 16; chunk++) begin
      pick = $urandom_range(0, 9);
      lim = (pick == 0) ? mbe_pkg::CNT_W'($urandom_range(0, 2))
                        : mbe_pkg::CNT_W'($urandom_range(1, 120));
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        zm = $urandom_range(32'h0010_0000, 32'h0100_0000);
      end else if (pick == 7) begin
        zm = '0;
      end else if (pick == 8) begin
        zm = 32'hFFFF_FFFF;
      end else begin
        zm = $urandom;
      end
      drain();
      program_view(lim, zm, random_offset(), random_offset(), random_dim(), random_dim());
      steady = (chunk == 6);
      span_x = (view.width == 0) ? 1 : ((view.width > 4096) ? 4096 : view.width);
      span_y = (view.height == 0) ? 1 : ((view.height > 4096) ? 4096 : view.height);
      for (int i = 0; i < 100; i++) begin
        x = ($urandom_range(0, 99) < 15) ? mbe_pkg::PIX_W'($urandom)
                                         : mbe_pkg::PIX_W'($urandom_range(0, span_x - 1));
        y = ($urandom_range(0, 99) < 15) ? mbe_pkg::PIX_W'($urandom)
                                         : mbe_pkg::PIX_W'($urandom_range(0, span_y - 1));
        queue_pixel(x, y);
      end
    end

    drain();
    steady = 1'b0;
    repeat (300) @(negedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
